[hw/rtl/integer_square_root_unit_macros.svh]
// Assertion macros shared by the square root unit.
`ifndef INTEGER_SQUARE_ROOT_UNIT_MACROS_SVH
`define INTEGER_SQUARE_ROOT_UNIT_MACROS_SVH

// Checked only outside reset.
`define ISQRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ISQRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/isqrt_pkg.sv]
package isqrt_pkg;

  localparam int unsigned RADICAND_BITS = 31;
  localparam int unsigned ROOT_BITS     = (RADICAND_BITS + 1) / 2;
  localparam int unsigned PAD_BITS      = 2 * ROOT_BITS;
  localparam int unsigned REM_BITS      = ROOT_BITS + 1;
  localparam int unsigned IN_TDATA_BITS  = ((RADICAND_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_BITS = ((ROOT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                 valid;
    logic [PAD_BITS-1:0]  x;
    logic [ROOT_BITS-1:0] q;
    logic [REM_BITS-1:0]  rem;
  } isqrt_cell_t;

endpackage

[hw/rtl/integer_square_root_unit.sv]
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata[30:0] radicand
// m_axis   | out | tdata[15:0] root = floor(sqrt(radicand))
//
// A chain of ROOT_BITS cells, one root bit per cell, one cell per cycle unless the chain is frozen.
// Each item passes through the cells and then the output register; one item in the chain at a time.
// A new beat is taken once the chain is empty, also while a result waits.
// A full output register with m_axis_tready low freezes the chain once an item sits in the last cell.
// Reset clears the valid bits only.
module integer_square_root_unit
  import isqrt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // [30:0] radicand
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata    // [15:0] root
);

`include "integer_square_root_unit_macros.svh"

  isqrt_cell_t          chain [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] cell_valid;
  logic                 chain_en;
  logic                 accept;
  logic                 out_valid_q, out_valid_d;
  logic [ROOT_BITS-1:0] out_root_q;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign chain_en = !(chain[ROOT_BITS].valid && out_valid_q && !m_axis_tready);

  assign chain[0] = '{
    valid: accept,
    x:     PAD_BITS'(s_axis_tdata[RADICAND_BITS-1:0]),
    q:     '0,
    rem:   '0
  };

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
    isqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (chain_en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
    assign cell_valid[i] = chain[i+1].valid;
  end

  assign s_axis_tready = ~|cell_valid;

  always_comb begin
    out_valid_d = out_valid_q;
    if (chain[ROOT_BITS].valid && chain_en) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain[ROOT_BITS].valid && chain_en) begin
      out_root_q <= chain[ROOT_BITS].q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_BITS'(out_root_q);

  `ISQRT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "result beat out of reset")
  `ISQRT_ASSERT(a_one_item, $onehot0(cell_valid), "more than one item in the chain")
  `ISQRT_ASSERT(a_accept_enters, accept |=> chain[1].valid, "accepted beat did not enter the chain")
  `ISQRT_ASSERT(a_stall_holds, !chain_en |=> chain[ROOT_BITS].valid && out_valid_q, "stalled result lost")
  `ISQRT_ASSERT(a_ready_empty, s_axis_tready |-> !chain[ROOT_BITS].valid, "ready with item in chain")

endmodule

[hw/rtl/isqrt_cell.sv]
module isqrt_cell
  import isqrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  isqrt_cell_t cell_i,
  output isqrt_cell_t cell_o
);

  logic                 valid_q;
  logic [PAD_BITS-1:0]  x_q, x_d;
  logic [ROOT_BITS-1:0] q_q, q_d;
  logic [REM_BITS-1:0]  rem_q, rem_d;
  logic [REM_BITS+1:0]  cand;
  logic [REM_BITS+1:0]  trial;
  logic [REM_BITS+1:0]  diff;

  // one root bit: bring down two radicand bits, try subtracting 4q+1
  always_comb begin
    cand  = {cell_i.rem, cell_i.x[PAD_BITS-1 -: 2]};
    trial = {1'b0, cell_i.q, 2'b01};
    diff  = cand - trial;
    x_d   = {cell_i.x[PAD_BITS-3:0], 2'b00};
    if (cand >= trial) begin
      rem_d = diff[REM_BITS-1:0];
      q_d   = {cell_i.q[ROOT_BITS-2:0], 1'b1};
    end else begin
      rem_d = cand[REM_BITS-1:0];
      q_d   = {cell_i.q[ROOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && cell_i.valid) begin
      x_q   <= x_d;
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end

  assign cell_o = '{valid: valid_q, x: x_q, q: q_q, rem: rem_q};

endmodule

[test/tb_integer_square_root_unit.sv]
module tb_integer_square_root_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import isqrt_pkg::*;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

  logic [OUT_TDATA_BITS-1:0] pending_roots[$];
  int unsigned               error_count = 0;
  int unsigned               burst_left = 0;
  int unsigned               hold_requests = 0;
  int unsigned               holds_served = 0;
  int unsigned               hold_left = 0;
  int unsigned               stall_mode = 0;
  int unsigned               mode_left = 0;
  int unsigned               cycle_count = 0;

  integer_square_root_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor(sqrt(n)), one root bit per step from the top; bits above the radicand are dropped
  function automatic logic [OUT_TDATA_BITS-1:0] floor_sqrt(input logic [IN_TDATA_BITS-1:0] word);
    logic [RADICAND_BITS-1:0] n;
    logic [ROOT_BITS-1:0]     r;
    logic [ROOT_BITS-1:0]     trial;
    logic [63:0]              sq;
    n = word[RADICAND_BITS-1:0];
    r = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial    = r;
      trial[b] = 1'b1;
      sq       = 64'(trial) * 64'(trial);
      if (sq <= 64'(n)) r = trial;
    end
    return OUT_TDATA_BITS'(r);
  endfunction

  function automatic logic [IN_TDATA_BITS-1:0] random_radicand();
    logic [31:0] w;
    int unsigned k;
    case ($urandom_range(0, 4))
      0: w = $urandom();
      1: begin
        k = $urandom_range(0, 46340);
        w = k * k + $urandom_range(0, 2) - 1;
        w[31] = 1'($urandom_range(0, 1));
      end
      2: begin
        w = $urandom_range(0, 1023);
        w[31] = 1'($urandom_range(0, 1));
      end
      3: w = $urandom() >> $urandom_range(0, 31);
      default: begin
        w = 32'h7FFF_FFFF - $urandom_range(0, 100000);
        w[31] = 1'($urandom_range(0, 1));
      end
    endcase
    return IN_TDATA_BITS'(w);
  endfunction

  task automatic send_radicand(input logic [IN_TDATA_BITS-1:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_roots.push_back(floor_sqrt(word));
  endtask

  task automatic wait_all_roots();
    s_axis_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [IN_TDATA_BITS-1:0] words[$];
    words = {32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd15, 32'd16,
             32'h4000_0000, 32'h3FFF_FFFF, 32'd2147395600, 32'd2147395599,
             32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
             32'h2AAA_AAAA, 32'h8000_0019, 32'd65536, 32'd65535};
    foreach (words[i]) send_radicand(words[i]);
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_radicand(random_radicand());
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    repeat (30) send_radicand(random_radicand());
  endtask

  task automatic test_drain_pauses();
    repeat (4) begin
      repeat (20) send_radicand(random_radicand());
      wait_all_roots();
    end
  endtask

  always @(posedge clk_i) begin
    logic [OUT_TDATA_BITS-1:0] want;
    cycle_count++;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_roots.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected root beat: got %0d", m_axis_tdata);
      end else begin
        want = pending_roots.pop_front();
        if (m_axis_tdata !== want) begin
          error_count++;
          if (error_count <= 10) $display("root mismatch: expected %0d got %0d", want, m_axis_tdata);
        end
      end
    end
    if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = 300;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= cycle_count[2];
      endcase
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400);
    test_backpressure();
    test_drain_pauses();
    test_random(370);
    wait_all_roots();
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && pending_roots.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/isqrt_pkg.sv
hw/rtl/isqrt_cell.sv
hw/rtl/integer_square_root_unit.sv
test/tb_integer_square_root_unit.sv
